// ===== sv/rpm_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the prim maze generator
// no dependencies
package rpm_pkg;

  localparam int MAX_SIDE       = 32;
  localparam int SIDE_W         = 5;
  localparam int DIM_W          = 6;
  localparam int FRONTIER_DEPTH = 4096;
  localparam int FADDR_W        = 12;
  localparam int CNT_W          = 13;
  localparam int RAND_W         = 32;

  typedef enum logic [1:0] {
    KIND_CARVED   = 2'd0,
    KIND_WALL     = 2'd1,
    KIND_FINISHED = 2'd2,
    KIND_STARTED  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    DIR_DOWN  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_LEFT  = 2'd3
  } dir_t;

  typedef enum logic [0:0] {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic [0:0] {
    REG_HEIGHT = 1'b0,
    REG_WIDTH  = 1'b1
  } reg_idx_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SEED0,
    ST_SEED1,
    ST_MOD,
    ST_EGET,
    ST_SHRD,
    ST_SHWR,
    ST_MAPRD,
    ST_MAPCHK,
    ST_NBSEL,
    ST_NBCK,
    ST_FIN
  } state_t;

  typedef struct packed {
    logic [SIDE_W-1:0] fr;
    logic [SIDE_W-1:0] fc;
    logic [SIDE_W-1:0] tr;
    logic [SIDE_W-1:0] tc;
  } entry_t;

endpackage

// ===== sv/randomized_prim_maze_generator.sv =====
`timescale 1ns / 1ps
// start item: two seed entries are written to the frontier (SEED0, SEED1) before the
// result; a step on an empty frontier goes straight to the result; a step runs the
// remainder unit, then shifts every frontier entry behind the chosen one down by one
// (order-keeping shift, read and write in turn), then checks up to four neighbours.
// one item at a time. synchronous active-low reset: frontier empty, maze
// closed, dimensions 15 by 15; the cell map is cleared through row valid bits.
module randomized_prim_maze_generator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] random_value
  input  logic        in_tuser,   // [0] op
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // from_row, from_col, to_row, to_col, frontier_size, zero fill
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,  // is_last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [5:0]  cfg_data
);

  localparam int SW = rpm_pkg::SIDE_W;
  localparam int CW = rpm_pkg::CNT_W;
  localparam int AW = rpm_pkg::FADDR_W;
  localparam int DW = rpm_pkg::DIM_W;
  localparam int MS = rpm_pkg::MAX_SIDE;

  rpm_pkg::state_t state_r, state_nxt;
  logic [DW-1:0]   h_r, h_nxt, w_r, w_nxt, h_use, w_use;
  logic [CW-1:0]   cnt_r, cnt_nxt, ptr_r, ptr_nxt, ptr_dec;
  rpm_pkg::entry_t ent_r, ent_nxt;
  rpm_pkg::kind_t  kind_r, kind_nxt;
  logic [1:0]      dir_r, dir_nxt;
  logic [MS-1:0]   row_vld_r, row_vld_nxt;
  logic [31:0]     rnd_r, rnd_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [39:0]     out_data_r, out_data_nxt;
  logic [1:0]      out_kind_r, out_kind_nxt;
  logic            out_last_r, out_last_nxt;

  // cell map: one row of open bits per word
  logic [MS-1:0]   map_mem [MS];
  logic            map_we, map_re;
  logic [SW-1:0]   map_waddr, map_raddr;
  logic [MS-1:0]   map_wdata, map_rdata_r, map_row;
  logic            map_rv_r;

  // frontier list
  rpm_pkg::entry_t fr_mem [rpm_pkg::FRONTIER_DEPTH];
  logic            fr_we, fr_re;
  logic [AW-1:0]   fr_waddr, fr_raddr;
  rpm_pkg::entry_t fr_wdata, fr_rdata_r;

  logic            mod_start, mod_done;
  logic [CW-1:0]   mod_rem;

  logic [DW-1:0]   nr, nc;
  logic            nb_in;

  rpm_mod u_mod (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mod_start),
    .num   (rnd_r),
    .den   (cnt_r),
    .done  (mod_done),
    .rem   (mod_rem)
  );

  always_comb begin
    h_use = (h_r < DW'(2)) ? DW'(2) : ((h_r > DW'(MS)) ? DW'(MS) : h_r);
    w_use = (w_r < DW'(2)) ? DW'(2) : ((w_r > DW'(MS)) ? DW'(MS) : w_r);
  end

  // neighbour coordinates; stepping below zero wraps high and fails the bound
  always_comb begin
    nr = {1'b0, ent_r.tr};
    nc = {1'b0, ent_r.tc};
    unique case (rpm_pkg::dir_t'(dir_r))
      rpm_pkg::DIR_DOWN:  nr = {1'b0, ent_r.tr} + DW'(1);
      rpm_pkg::DIR_RIGHT: nc = {1'b0, ent_r.tc} + DW'(1);
      rpm_pkg::DIR_UP:    nr = {1'b0, ent_r.tr} - DW'(1);
      rpm_pkg::DIR_LEFT:  nc = {1'b0, ent_r.tc} - DW'(1);
      default: ;
    endcase
    nb_in = (nr < h_use) && (nc < w_use);
  end

  assign map_row   = map_rv_r ? map_rdata_r : '0;
  assign ptr_dec   = ptr_r - CW'(1);
  assign in_tready = (state_r == rpm_pkg::ST_IDLE);
  assign cfg_ready = 1'b1;

  always_comb begin
    state_nxt     = state_r;
    h_nxt         = h_r;
    w_nxt         = w_r;
    cnt_nxt       = cnt_r;
    ptr_nxt       = ptr_r;
    ent_nxt       = ent_r;
    kind_nxt      = kind_r;
    dir_nxt       = dir_r;
    row_vld_nxt   = row_vld_r;
    rnd_nxt       = rnd_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    out_data_nxt  = out_data_r;
    out_kind_nxt  = out_kind_r;
    out_last_nxt  = out_last_r;
    map_we        = 1'b0;
    map_waddr     = ent_r.tr;
    map_wdata     = map_row;
    map_re        = 1'b0;
    map_raddr     = ent_r.tr;
    fr_we         = 1'b0;
    fr_waddr      = cnt_r[AW-1:0];
    fr_wdata      = '0;
    fr_re         = 1'b0;
    fr_raddr      = ptr_r[AW-1:0];
    mod_start     = 1'b0;

    if (cfg_valid) begin
      if (rpm_pkg::reg_idx_t'(cfg_index) == rpm_pkg::REG_HEIGHT) begin
        h_nxt = cfg_data;
      end else begin
        w_nxt = cfg_data;
      end
    end

    unique case (state_r)
      rpm_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          ent_nxt = '0;
          if (rpm_pkg::op_t'(in_tuser) == rpm_pkg::OP_START) begin
            row_vld_nxt    = '0;
            row_vld_nxt[0] = 1'b1;
            map_we         = 1'b1;
            map_waddr      = '0;
            map_wdata      = MS'(1);
            cnt_nxt        = '0;
            kind_nxt       = rpm_pkg::KIND_STARTED;
            state_nxt      = rpm_pkg::ST_SEED0;
          end else if (cnt_r == '0) begin
            kind_nxt  = rpm_pkg::KIND_FINISHED;
            state_nxt = rpm_pkg::ST_FIN;
          end else begin
            rnd_nxt   = in_tdata;
            state_nxt = rpm_pkg::ST_MOD;
          end
        end
      end
      rpm_pkg::ST_SEED0: begin
        fr_we     = 1'b1;
        fr_waddr  = '0;
        fr_wdata  = '{fr: '0, fc: '0, tr: '0, tc: SW'(1)};
        state_nxt = rpm_pkg::ST_SEED1;
      end
      rpm_pkg::ST_SEED1: begin
        fr_we     = 1'b1;
        fr_waddr  = AW'(1);
        fr_wdata  = '{fr: '0, fc: '0, tr: SW'(1), tc: '0};
        cnt_nxt   = CW'(2);
        state_nxt = rpm_pkg::ST_FIN;
      end
      rpm_pkg::ST_MOD: begin
        // start pulse on the first cycle, identified by a nonzero pointer that is then cleared
        if (ptr_r != CW'(0) || !mod_done) begin
          mod_start = (ptr_r != CW'(0));
          ptr_nxt   = '0;
        end
        if (mod_done) begin
          fr_re     = 1'b1;
          fr_raddr  = mod_rem[AW-1:0];
          ptr_nxt   = mod_rem;
          state_nxt = rpm_pkg::ST_EGET;
        end
      end
      rpm_pkg::ST_EGET: begin
        ent_nxt   = fr_rdata_r;
        ptr_nxt   = ptr_r + CW'(1);
        state_nxt = rpm_pkg::ST_SHRD;
      end
      rpm_pkg::ST_SHRD: begin
        if (ptr_r < cnt_r) begin
          fr_re     = 1'b1;
          state_nxt = rpm_pkg::ST_SHWR;
        end else begin
          cnt_nxt   = cnt_r - CW'(1);
          state_nxt = rpm_pkg::ST_MAPRD;
        end
      end
      rpm_pkg::ST_SHWR: begin
        fr_we     = 1'b1;
        fr_waddr  = ptr_dec[AW-1:0];
        fr_wdata  = fr_rdata_r;
        ptr_nxt   = ptr_r + CW'(1);
        state_nxt = rpm_pkg::ST_SHRD;
      end
      rpm_pkg::ST_MAPRD: begin
        map_re    = 1'b1;
        state_nxt = rpm_pkg::ST_MAPCHK;
      end
      rpm_pkg::ST_MAPCHK: begin
        if (map_row[ent_r.tc]) begin
          kind_nxt  = rpm_pkg::KIND_WALL;
          state_nxt = rpm_pkg::ST_FIN;
        end else begin
          map_we                 = 1'b1;
          map_wdata              = map_row | (MS'(1) << ent_r.tc);
          row_vld_nxt[ent_r.tr]  = 1'b1;
          kind_nxt               = rpm_pkg::KIND_CARVED;
          dir_nxt                = '0;
          state_nxt              = rpm_pkg::ST_NBSEL;
        end
      end
      rpm_pkg::ST_NBSEL: begin
        if (nb_in) begin
          map_re    = 1'b1;
          map_raddr = nr[SW-1:0];
          state_nxt = rpm_pkg::ST_NBCK;
        end else if (dir_r == 2'd3) begin
          state_nxt = rpm_pkg::ST_FIN;
        end else begin
          dir_nxt = dir_r + 2'd1;
        end
      end
      rpm_pkg::ST_NBCK: begin
        if (!map_row[nc[SW-1:0]] && cnt_r < CW'(rpm_pkg::FRONTIER_DEPTH)) begin
          fr_we    = 1'b1;
          fr_wdata = '{fr: ent_r.tr, fc: ent_r.tc, tr: nr[SW-1:0], tc: nc[SW-1:0]};
          cnt_nxt  = cnt_r + CW'(1);
        end
        if (dir_r == 2'd3) begin
          state_nxt = rpm_pkg::ST_FIN;
        end else begin
          dir_nxt   = dir_r + 2'd1;
          state_nxt = rpm_pkg::ST_NBSEL;
        end
      end
      rpm_pkg::ST_FIN: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_kind_nxt  = kind_r;
          out_last_nxt  = (cnt_r == '0);
          out_data_nxt  = {7'd0, cnt_r, ent_r.tc, ent_r.tr, ent_r.fc, ent_r.fr};
          ptr_nxt       = CW'(1);
          state_nxt     = rpm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rpm_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpm_pkg::ST_IDLE;
      h_r         <= DW'(15);
      w_r         <= DW'(15);
      cnt_r       <= '0;
      ptr_r       <= CW'(1);
      row_vld_r   <= '0;
      out_valid_r <= 1'b0;
      kind_r      <= rpm_pkg::KIND_FINISHED;
      dir_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      h_r         <= h_nxt;
      w_r         <= w_nxt;
      cnt_r       <= cnt_nxt;
      ptr_r       <= ptr_nxt;
      row_vld_r   <= row_vld_nxt;
      out_valid_r <= out_valid_nxt;
      kind_r      <= kind_nxt;
      dir_r       <= dir_nxt;
    end
    ent_r      <= ent_nxt;
    rnd_r      <= rnd_nxt;
    out_data_r <= out_data_nxt;
    out_kind_r <= out_kind_nxt;
    out_last_r <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (map_we) begin
      map_mem[map_waddr] <= map_wdata;
    end
    if (map_re) begin
      map_rdata_r <= map_mem[map_raddr];
      map_rv_r    <= row_vld_r[map_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (fr_we) begin
      fr_mem[fr_waddr] <= fr_wdata;
    end
    if (fr_re) begin
      fr_rdata_r <= fr_mem[fr_raddr];
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

endmodule

// ===== sv/rpm_mod.sv =====
`timescale 1ns / 1ps
// restoring remainder unit: 32-bit word mod frontier count, one bit per cycle
// depends on rpm_pkg
module rpm_mod (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  logic [rpm_pkg::RAND_W-1:0] num,
  input  logic [rpm_pkg::CNT_W-1:0]  den,
  output logic                      done,
  output logic [rpm_pkg::CNT_W-1:0]  rem
);

  logic [rpm_pkg::RAND_W-1:0] num_r, num_nxt;
  logic [rpm_pkg::CNT_W-1:0]  rem_r, rem_nxt;
  logic [rpm_pkg::CNT_W-1:0]  den_r, den_nxt;
  logic [4:0]                 bit_r, bit_nxt;
  logic                       busy_r, busy_nxt;
  logic                       done_r, done_nxt;
  logic [rpm_pkg::CNT_W:0]    trial;
  logic [rpm_pkg::CNT_W:0]    diff;

  always_comb begin
    num_nxt  = num_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    bit_nxt  = bit_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial    = {rem_r, num_r[rpm_pkg::RAND_W-1]};
    diff     = trial - {1'b0, den_r};
    if (start) begin
      num_nxt  = num;
      den_nxt  = den;
      rem_nxt  = '0;
      bit_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      num_nxt = {num_r[rpm_pkg::RAND_W-2:0], 1'b0};
      if (trial >= {1'b0, den_r}) begin
        rem_nxt = diff[rpm_pkg::CNT_W-1:0];
      end else begin
        rem_nxt = trial[rpm_pkg::CNT_W-1:0];
      end
      bit_nxt = bit_r + 5'd1;
      if (bit_r == 5'd31) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      bit_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      bit_r  <= bit_nxt;
    end
    num_r <= num_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// testbench for the prim maze generator: directed table then random steps,
// results checked against a behavioral maze carver; depends on rpm_pkg
module tb;

  typedef struct packed {
    logic [4:0] fr, fc, tr, tc;
  } passage_t;

  typedef struct {
    rpm_pkg::kind_t kind;
    logic [4:0]     fr, fc, tr, tc;
    logic [12:0]    fsize;
    logic           last;
  } maze_result_t;

  typedef struct {
    rpm_pkg::op_t   op;
    logic [31:0]    rnd;
    logic           known;
    rpm_pkg::kind_t kind;
    logic [12:0]    fsize;
    logic           last;
  } stim_row_t;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_tvalid = 0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;
  logic        in_tuser = 0;
  logic        out_tvalid;
  logic        out_tready = 0;
  logic [39:0] out_tdata;
  logic [1:0]  out_tuser;
  logic        out_tlast;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic        cfg_index = 0;
  logic [5:0]  cfg_data = '0;

  always #6 clk = ~clk;

  randomized_prim_maze_generator DUT (.*);

  // model state
  logic [5:0]   height_reg, width_reg;
  bit           open_map [rpm_pkg::MAX_SIDE*rpm_pkg::MAX_SIDE];
  passage_t     frontier [$];
  maze_result_t pending_results [$];

  int  mismatches = 0;
  int  idle_cycles = 0;
  bit  stall_long = 0;

  stim_row_t directed [$];

  function automatic int clamp_side(logic [5:0] v);
    if (v < 2) return 2;
    if (v > rpm_pkg::MAX_SIDE) return rpm_pkg::MAX_SIDE;
    return v;
  endfunction

  function automatic void push_passage(int fr, int fc, int tr, int tc);
    if (frontier.size() < rpm_pkg::FRONTIER_DEPTH)
      frontier.insert(frontier.size(), passage_t'{fr[4:0], fc[4:0], tr[4:0], tc[4:0]});
  endfunction

  function automatic void add_row(rpm_pkg::op_t op, logic [31:0] rnd, logic known,
                                  rpm_pkg::kind_t kind, logic [12:0] fsize, logic last);
    stim_row_t s;
    s = '{op, rnd, known, kind, fsize, last};
    directed.insert(directed.size(), s);
  endfunction

  function automatic maze_result_t carve_step(rpm_pkg::op_t op, logic [31:0] rnd);
    maze_result_t r;
    passage_t     p;
    int           h, w, k, nr, nc;
    int           drow [4] = '{1, 0, -1, 0};
    int           dcol [4] = '{0, 1, 0, -1};
    h = clamp_side(height_reg);
    w = clamp_side(width_reg);
    r = '{rpm_pkg::KIND_FINISHED, 0, 0, 0, 0, 0, 0};
    if (op == rpm_pkg::OP_START) begin
      foreach (open_map[i]) open_map[i] = 0;
      frontier.delete();
      open_map[0] = 1;
      push_passage(0, 0, 0, 1);
      push_passage(0, 0, 1, 0);
      r.kind = rpm_pkg::KIND_STARTED;
    end else if (frontier.size() != 0) begin
      k = rnd % frontier.size();
      p = frontier[k];
      frontier.delete(k);
      r.fr = p.fr; r.fc = p.fc; r.tr = p.tr; r.tc = p.tc;
      if (open_map[p.tr*rpm_pkg::MAX_SIDE + p.tc]) begin
        r.kind = rpm_pkg::KIND_WALL;
      end else begin
        open_map[p.tr*rpm_pkg::MAX_SIDE + p.tc] = 1;
        for (int d = 0; d < 4; d++) begin
          nr = p.tr + drow[d];
          nc = p.tc + dcol[d];
          if (nr < 0 || nc < 0 || nr >= h || nc >= w) continue;
          if (!open_map[nr*rpm_pkg::MAX_SIDE + nc]) push_passage(p.tr, p.tc, nr, nc);
        end
        r.kind = rpm_pkg::KIND_CARVED;
      end
    end
    r.fsize = 13'(frontier.size());
    r.last  = (frontier.size() == 0);
    return r;
  endfunction

  // valid stays up after an accept until the next call decides on a gap
  task automatic send_item(rpm_pkg::op_t op, logic [31:0] rnd);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      in_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser  <= op;
    in_tdata  <= rnd;
    do @(posedge clk); while (!in_tready);
    pending_results.insert(pending_results.size(), carve_step(op, rnd));
  endtask

  task automatic write_reg(rpm_pkg::reg_idx_t idx, logic [5:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    if (idx == rpm_pkg::REG_HEIGHT) height_reg = val; else width_reg = val;
    @(posedge clk);
  endtask

  task automatic drain;
    in_tvalid <= 0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // receiver
  initial begin
    forever begin
      @(posedge clk);
      if (stall_long) out_tready <= 0;
      else if ($urandom_range(0, 3) == 0) out_tready <= 1;
      else out_tready <= ($urandom_range(0, 18) == 0);
    end
  end

  // checker
  always @(posedge clk) begin
    maze_result_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h %h", out_tuser, out_tdata);
      end else begin
        e = pending_results.pop_front();
        if (out_tuser != e.kind || out_tdata[4:0] != e.fr || out_tdata[9:5] != e.fc ||
            out_tdata[14:10] != e.tr || out_tdata[19:15] != e.tc ||
            out_tdata[32:20] != e.fsize || out_tlast != e.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp kind %0d %0d,%0d->%0d,%0d size %0d last %0b got %0d %h %0b",
                     e.kind, e.fr, e.fc, e.tr, e.tc, e.fsize, e.last,
                     out_tuser, out_tdata, out_tlast);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 50000) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int           steps;
    maze_result_t e;
    logic [5:0]   dims [8];
    height_reg = 15;
    width_reg  = 15;
    foreach (open_map[i]) open_map[i] = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // step after reset, start, extremes of the random word, then a maze walk
    add_row(rpm_pkg::OP_STEP, 32'h0, 1, rpm_pkg::KIND_FINISHED, 13'd0, 1'b1);
    add_row(rpm_pkg::OP_START, 32'hFFFFFFFF, 1, rpm_pkg::KIND_STARTED, 13'd2, 1'b0);
    add_row(rpm_pkg::OP_STEP, 32'hFFFFFFFF, 0, rpm_pkg::KIND_CARVED, 13'd0, 1'b0);
    add_row(rpm_pkg::OP_STEP, 32'h0, 0, rpm_pkg::KIND_CARVED, 13'd0, 1'b0);
    for (int i = 0; i < 14; i++)
      add_row(rpm_pkg::OP_STEP, $urandom, 0, rpm_pkg::KIND_CARVED, 13'd0, 1'b0);
    add_row(rpm_pkg::OP_START, 32'h0, 1, rpm_pkg::KIND_STARTED, 13'd2, 1'b0);
    foreach (directed[i]) begin
      send_item(directed[i].op, directed[i].rnd);
      if (directed[i].known) begin
        e = pending_results[$];
        if (e.kind != directed[i].kind || e.fsize != directed[i].fsize ||
            e.last != directed[i].last) begin
          mismatches++;
          if (mismatches <= 10) $display("table row %0d disagrees with predictor", i);
        end
      end
    end
    drain();

    // small grids, extremes, out-of-range values
    dims = '{6'd2, 6'd32, 6'd0, 6'd63, 6'd3, 6'd7, 6'd1, 6'd40};
    for (int ph = 0; ph < 10; ph++) begin
      write_reg(rpm_pkg::REG_HEIGHT, ph < 8 ? dims[ph] : 6'($urandom_range(2, 9)));
      write_reg(rpm_pkg::REG_WIDTH, ph < 8 ? dims[7 - ph] : 6'($urandom_range(2, 9)));
      if (ph == 3) fork
        begin
          stall_long = 1;
          repeat (3000) @(posedge clk);
          stall_long = 0;
        end
      join_none
      steps = (ph == 1 || ph == 3) ? 300 : 110;
      send_item(rpm_pkg::OP_START, $urandom);
      for (int i = 0; i < steps; i++) begin
        if ($urandom_range(0, 60) == 0) send_item(rpm_pkg::OP_START, $urandom);
        else send_item(rpm_pkg::OP_STEP, $urandom);
        // bounds only change while idle, so that is done between phases
      end
      drain();
    end
    write_reg(rpm_pkg::REG_HEIGHT, 6'd15);
    write_reg(rpm_pkg::REG_WIDTH, 6'd15);
    send_item(rpm_pkg::OP_START, 32'h0);
    for (int i = 0; i < 80; i++) send_item(rpm_pkg::OP_STEP, $urandom);
    drain();

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule

// ===== files.f =====
sv/rpm_pkg.sv
sv/rpm_mod.sv
sv/randomized_prim_maze_generator.sv
tb/sv/tb.sv
